### src/bst_pkg.sv
// bst_pkg: shared constants, codes and control structs for the bounded set table.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    // Store geometry
    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Item field widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int OCC_W    = 8;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    // Command codes
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture value, rewind pointer
        logic scan;         // advance the search read pipeline
        logic start_shift;  // record hit index, point past it
        logic shift;        // advance the move-down pipeline with writeback
        logic set_hit;      // result: done at the hit index
        logic set_refused;  // result: refused
        logic set_full;     // result: refused, store full
        logic append;       // write value at the end, count up
        logic remove_done;  // count down, result at the removed index
        logic clear;        // empty the set
        logic emit;         // load the output register
    } bst_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;          // compared entry equals the value
        logic scan_end;     // no more entries to read, pipeline drained
        logic full;         // occupancy equals capacity
        logic out_free;     // output register can take a result
    } bst_stat_t;

endpackage

`default_nettype wire

### src/bst_ctrl.sv
// bst_ctrl: command sequencer for the bounded set table.
// Depends on bst_pkg; drives bst_dp through bst_cmd_t and reads bst_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module bst_ctrl
    import bst_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [OP_W-1:0] in_op,
    input  wire bst_stat_t       stat,
    output bst_cmd_t             cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;

    // Hold state and command code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_FIND;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequence one item: search (none for clear), optional move-down, then deliver
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_op;
                    cmd.load = 1'b1;
                    if (in_op == OP_CLEAR)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    case (op_reg)
                        OP_FIND:
                        begin
                            cmd.set_hit = 1'b1;
                            state_next  = S_FINISH;
                        end
                        OP_REMOVE:
                        begin
                            cmd.start_shift = 1'b1;
                            state_next      = S_SHIFT;
                        end
                        default:
                        begin
                            cmd.set_refused = 1'b1;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
                else if (stat.scan_end)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (stat.full)
                            cmd.set_full = 1'b1;
                        else
                            cmd.append = 1'b1;
                    end
                    else
                    begin
                        cmd.set_refused = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.scan_end)
                begin
                    cmd.remove_done = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/bst_dp.sv
// bst_dp: element store, read pipeline, occupancy and output register.
// Depends on bst_pkg; commanded by bst_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bst_dp
    import bst_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [VALUE_W-1:0] in_value,
    input  wire bst_cmd_t           cmd,
    output bst_stat_t               stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [STATUS_W-1:0]     out_status,
    output logic [POS_W-1:0]        out_position,
    output logic [OCC_W-1:0]        out_occupancy
);

    logic [VALUE_W-1:0]  elem_mem [CAPACITY];

    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rd_valid_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [VALUE_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]    found_idx_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic [OCC_W-1:0]    out_occ_reg;

    logic                rd_en;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;

    // Issue a read while entries remain below the occupancy
    assign rd_en = (cmd.scan || cmd.shift) && (ptr_reg < count_reg);

    // Write port: append at the end or move an entry down one place
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = value_reg;
        if (cmd.append)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.shift && rd_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_reg - IDX_W'(1);
            mem_wdata = rd_data_reg;
        end
    end

    // Element store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            elem_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= elem_mem[ptr_reg[IDX_W-1:0]];
    end

    // Pointer, occupancy and result fields
    always_comb
    begin
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        if (cmd.load)
            ptr_next = '0;
        else if (cmd.start_shift)
            ptr_next = CNT_W'(rd_idx_reg) + CNT_W'(1);
        else if (rd_en)
            ptr_next = ptr_reg + CNT_W'(1);

        if (cmd.set_hit)
        begin
            res_status_next = ST_DONE;
            res_pos_next    = POS_W'(rd_idx_reg);
        end
        if (cmd.set_refused)
        begin
            res_status_next = ST_REFUSED;
            res_pos_next    = '0;
        end
        if (cmd.set_full)
        begin
            res_status_next = ST_FULL;
            res_pos_next    = '0;
        end
        if (cmd.append)
        begin
            res_status_next = ST_DONE;
            res_pos_next    = POS_W'(count_reg[IDX_W-1:0]);
            count_next      = count_reg + CNT_W'(1);
        end
        if (cmd.remove_done)
        begin
            res_status_next = ST_DONE;
            res_pos_next    = POS_W'(found_idx_reg);
            count_next      = count_reg - CNT_W'(1);
        end
        if (cmd.clear)
        begin
            res_status_next = ST_DONE;
            res_pos_next    = '0;
            count_next      = '0;
        end
    end

    // Drop the output item once taken, load a new one on emit
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            value_reg <= in_value;
        if (rd_en)
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
        if (cmd.start_shift)
            found_idx_reg <= rd_idx_reg;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_occ_reg    <= OCC_W'(count_reg);
        end
    end

    // Status back to the controller
    assign stat.hit      = rd_valid_reg && (rd_data_reg == value_reg);
    assign stat.scan_end = !rd_valid_reg && (ptr_reg >= count_reg);
    assign stat.full     = (count_reg == CNT_W'(CAPACITY));
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_position  = out_pos_reg;
    assign out_occupancy = out_occ_reg;

endmodule

`default_nettype wire

### src/bounded_set_table_unit.sv
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tuser: cmd; s_tdata: value
// m_*      out        m_tvalid/m_tready  m_tdata: status, position, occupancy
//
// Time from accept to next accept grows with the entries compared and, on a remove,
// with the entries above the removed one that move down; clear does not search. With
// no output stall the longest items are removes from a full store, such as a remove at
// entry 0, set by the single read port of the store.
// Reset clears the occupancy; entries are not cleared and are read only below it.
// A finished result waits in the output register; the next item is taken meanwhile,
// and only its delivery waits for m_tready.
//
// bounded_set_table_unit: top level, joins bst_ctrl and bst_dp. Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bounded_set_table_unit
    import bst_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [OP_W-1:0]     s_tuser,   // [1:0] cmd
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata    // [1:0] status, [8:2] position,
                                                // [16:9] occupancy, [23:17] zero
);

    bst_cmd_t            cmd;
    bst_stat_t           stat;
    logic [STATUS_W-1:0] out_status;
    logic [POS_W-1:0]    out_position;
    logic [OCC_W-1:0]    out_occupancy;

    // Sequencer
    bst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store and result path
    bst_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_value      (s_tdata[VALUE_W-1:0]),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (out_status),
        .out_position  (out_position),
        .out_occupancy (out_occupancy)
    );

    // Pack the result item
    assign m_tdata = {(M_DATA_W - STATUS_W - POS_W - OCC_W)'(0),
                      out_occupancy, out_position, out_status};

endmodule

`default_nettype wire

### src/bst_checker.sv
// bst_checker: port-level checks for bounded_set_table_unit, attached by bind.
// Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_checker
    import bst_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: accepting an item closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after an accept");

    // Refusals report position zero
    a_refused_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_REFUSED || m_tdata[1:0] == ST_FULL)
        |-> m_tdata[8:2] == '0)
        else $error("refused result with nonzero position");

    // Occupancy never exceeds the capacity
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:9] <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    // Full refusal only at full occupancy
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[16:9] == OCC_W'(CAPACITY))
        else $error("full refusal below capacity");

endmodule

bind bounded_set_table_unit bst_checker u_bst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
